[design/fasc_pkg.sv]
// Shared constants, codes and types of the frame allocator.
`timescale 1ns / 1ps
package fasc_pkg;

  parameter int NUM_FRAMES = 1024;
  parameter int FRAME_W    = 10;
  parameter int OWNER_W    = 6;
  parameter int KIND_W     = 2;
  parameter int COUNT_W    = 11;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_REF   = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_CHECK = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFRAME = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RING,
    S_VICTIM,
    S_OP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               mapped;
    logic               queued;
    logic               refd;
    logic [OWNER_W-1:0] owner;
    logic [KIND_W-1:0]  kind;
  } frame_word_t;

endpackage

[design/fasc_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module fasc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[design/frame_allocator_second_chance_core.sv]
// Frame allocator with second-chance replacement: controller, frame table and order ring.
//
// After reset the block clears every entry of the frame table and accepts no
// transaction until then; the configuration register can be written at any time.
// Reference, free and check read the frame entry, then update it in the operation
// state. Allocate scans the frame table one entry per cycle until it finds an
// unmapped frame; when every frame is mapped, second chance is on and the ring is not
// empty, each look at the ring head takes one ring read and one frame table read, up
// to ring_count + 1 looks. Each memory has a single read port. A finished result waits
// in the output register while the next transaction is accepted.
`timescale 1ns / 1ps
module frame_allocator_second_chance_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [fasc_pkg::FRAME_W-1:0] frame_i,
  input  logic [fasc_pkg::OWNER_W-1:0] owner_i,
  input  logic [fasc_pkg::KIND_W-1:0]  kind_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fasc_pkg::FRAME_W-1:0] frame_index_o,
  output logic [1:0]                  status_o,
  output logic                        evicted_o
);
  import fasc_pkg::*;

  localparam logic [FRAME_W-1:0] LAST_F  = FRAME_W'(NUM_FRAMES - 1);
  localparam logic [COUNT_W-1:0] FULL_C  = COUNT_W'(NUM_FRAMES);

  state_e               state_q, state_d;
  logic [1:0]           act_q, act_d;
  logic [FRAME_W-1:0]   frm_q, frm_d;
  logic [OWNER_W-1:0]   own_q, own_d;
  logic [KIND_W-1:0]    knd_q, knd_d;
  logic [FRAME_W-1:0]   scan_q, scan_d;
  logic [FRAME_W-1:0]   head_q, head_d;
  logic [FRAME_W-1:0]   tail_q, tail_d;
  logic [COUNT_W-1:0]   cnt_q, cnt_d;
  logic                 sc_on_q;
  logic                 fwd_vld_q, fwd_vld_d;
  logic [FRAME_W-1:0]   fwd_q, fwd_d;
  logic [FRAME_W-1:0]   res_idx_q, res_idx_d;
  logic [1:0]           res_st_q, res_st_d;
  logic                 res_ev_q, res_ev_d;
  logic                 out_valid_q, out_valid_d;
  logic [FRAME_W-1:0]   out_idx_q, out_idx_d;
  logic [1:0]           out_st_q, out_st_d;
  logic                 out_ev_q, out_ev_d;

  logic                 fm_we;
  logic [FRAME_W-1:0]   fm_waddr, fm_raddr;
  frame_word_t          fm_wdata, fw;
  logic                 rg_we;
  logic [FRAME_W-1:0]   rg_waddr, rg_raddr, rg_wdata, rg_rdata;
  logic [FRAME_W-1:0]   h_sel, head_nx, tail_nx;
  logic                 out_free, in_range;

  fasc_ram #(.W($bits(frame_word_t)), .D(NUM_FRAMES)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (fm_waddr),
    .wdata_i (fm_wdata),
    .raddr_i (fm_raddr),
    .rdata_o (fw)
  );

  fasc_ram #(.W(FRAME_W), .D(NUM_FRAMES)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (rg_we),
    .waddr_i (rg_waddr),
    .wdata_i (rg_wdata),
    .raddr_i (rg_raddr),
    .rdata_o (rg_rdata)
  );

  assign h_sel    = fwd_vld_q ? fwd_q : rg_rdata;
  assign head_nx  = (head_q == LAST_F) ? '0 : head_q + 1'b1;
  assign tail_nx  = (tail_q == LAST_F) ? '0 : tail_q + 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_range = {1'b0, frame_i} < FULL_C;

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign frame_index_o = out_idx_q;
  assign status_o      = out_st_q;
  assign evicted_o     = out_ev_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (scan_q == LAST_F) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (action_e'(action_i) == ACT_ALLOC) state_d = S_SCAN;
          else if (!in_range)                   state_d = S_DONE;
          else                                  state_d = S_OP;
        end
      end
      S_SCAN: begin
        if (!fw.mapped) state_d = S_DONE;
        else if (scan_q == LAST_F) state_d = (sc_on_q && cnt_q != '0) ? S_RING : S_DONE;
      end
      S_RING:   state_d = S_VICTIM;
      S_VICTIM: state_d = fw.refd ? S_RING : S_DONE;
      S_OP:     state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    act_d       = act_q;
    frm_d       = frm_q;
    own_d       = own_q;
    knd_d       = knd_q;
    scan_d      = scan_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    fwd_vld_d   = 1'b0;
    fwd_d       = fwd_q;
    res_idx_d   = res_idx_q;
    res_st_d    = res_st_q;
    res_ev_d    = res_ev_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_st_d    = out_st_q;
    out_ev_d    = out_ev_q;
    fm_we       = 1'b0;
    fm_waddr    = frm_q;
    fm_wdata    = fw;
    fm_raddr    = scan_q;
    rg_we       = 1'b0;
    rg_waddr    = tail_q;
    rg_wdata    = frm_q;
    rg_raddr    = head_q;
    case (state_q)
      S_CLEAR: begin
        fm_we    = 1'b1;
        fm_waddr = scan_q;
        fm_wdata = '0;
        scan_d   = scan_q + 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          act_d     = action_i;
          frm_d     = frame_i;
          own_d     = owner_i;
          knd_d     = kind_i;
          res_idx_d = frame_i;
          res_st_d  = ST_OK;
          res_ev_d  = 1'b0;
          if (action_e'(action_i) == ACT_ALLOC) begin
            fm_raddr = '0;
            scan_d   = '0;
          end else begin
            fm_raddr = frame_i;
            if (!in_range) res_st_d = ST_BAD;
          end
        end
      end
      S_SCAN: begin
        fm_raddr = scan_q + 1'b1;
        scan_d   = scan_q + 1'b1;
        if (!fw.mapped) begin
          fm_we     = 1'b1;
          fm_waddr  = scan_q;
          fm_wdata  = '{mapped: 1'b1, queued: fw.queued, refd: fw.refd,
                        owner: own_q, kind: knd_q};
          res_idx_d = scan_q;
        end else if (scan_q == LAST_F) begin
          if (!(sc_on_q && cnt_q != '0)) begin
            res_idx_d = '0;
            res_st_d  = ST_NOFRAME;
          end
        end
      end
      S_RING: begin
        fm_raddr = h_sel;
        frm_d    = h_sel;
      end
      S_VICTIM: begin
        fm_we  = 1'b1;
        head_d = head_nx;
        if (fw.refd) begin
          fm_wdata  = '{mapped: fw.mapped, queued: fw.queued, refd: 1'b0,
                        owner: fw.owner, kind: fw.kind};
          rg_we     = 1'b1;
          tail_d    = tail_nx;
          rg_raddr  = head_nx;
          fwd_vld_d = (head_nx == tail_q);
          fwd_d     = frm_q;
        end else begin
          fm_wdata  = '{mapped: 1'b1, queued: 1'b0, refd: 1'b0,
                        owner: own_q, kind: knd_q};
          cnt_d     = cnt_q - 1'b1;
          res_idx_d = frm_q;
          res_ev_d  = 1'b1;
        end
      end
      S_OP: begin
        case (action_e'(act_q))
          ACT_REF: begin
            fm_we = 1'b1;
            if (fw.queued) begin
              fm_wdata.refd = 1'b1;
            end else begin
              fm_wdata.queued = 1'b1;
              fm_wdata.refd   = 1'b0;
              if (cnt_q != FULL_C) begin
                rg_we  = 1'b1;
                tail_d = tail_nx;
                cnt_d  = cnt_q + 1'b1;
              end
            end
          end
          ACT_FREE: begin
            if (fw.mapped) begin
              fm_we           = 1'b1;
              fm_wdata.mapped = 1'b0;
            end else begin
              res_st_d = ST_BAD;
            end
          end
          ACT_CHECK: if (!fw.mapped || fw.owner != own_q) res_st_d = ST_BAD;
          default: ;
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_idx_q;
          out_st_d    = res_st_q;
          out_ev_d    = res_ev_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      scan_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      sc_on_q     <= 1'b1;
      fwd_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      fwd_vld_q   <= fwd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        sc_on_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    frm_q     <= frm_d;
    own_q     <= own_d;
    knd_q     <= knd_d;
    fwd_q     <= fwd_d;
    res_idx_q <= res_idx_d;
    res_st_q  <= res_st_d;
    res_ev_q  <= res_ev_d;
    out_idx_q <= out_idx_d;
    out_st_q  <= out_st_d;
    out_ev_q  <= out_ev_d;
  end
endmodule

[design/fasc_checker.sv]
// Port-level checks for the frame allocator and their binding to the top level.
`timescale 1ns / 1ps
module fasc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [fasc_pkg::FRAME_W-1:0] frame_index_o,
  input logic [1:0]                  status_o,
  input logic                        evicted_o
);
  import fasc_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_NOFRAME || status_o == ST_BAD))
    else $error("undefined status code");

  a_evict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_o) |-> (status_o == ST_OK))
    else $error("eviction with failing status");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NOFRAME) |-> (frame_index_o == '0 && !evicted_o))
    else $error("failed allocate with nonzero frame or eviction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(frame_index_o)))
    else $error("stalled transaction changed");
endmodule

bind frame_allocator_second_chance_core fasc_checker u_fasc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .frame_index_o (frame_index_o),
  .status_o      (status_o),
  .evicted_o     (evicted_o)
);

[dv/tb_frame_allocator_second_chance_core.sv]
// Self-checking testbench for the second-chance frame allocator core.
`timescale 1ns / 1ps
module tb_frame_allocator_second_chance_core;
  import fasc_pkg::*;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic [1:0]         status;
    logic               evicted;
  } alloc_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i = '0;
  logic [FRAME_W-1:0]  frame_i = '0;
  logic [OWNER_W-1:0]  owner_i = '0;
  logic [KIND_W-1:0]   kind_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [FRAME_W-1:0]  frame_index_o;
  logic [1:0]          status_o;
  logic                evicted_o;

  frame_allocator_second_chance_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .action_i(action_i), .frame_i(frame_i), .owner_i(owner_i), .kind_i(kind_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .frame_index_o(frame_index_o), .status_o(status_o), .evicted_o(evicted_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // frame table shadow
  bit                 mapped_q [NUM_FRAMES];
  bit                 queued_q [NUM_FRAMES];
  bit                 refbit_q [NUM_FRAMES];
  logic [OWNER_W-1:0] owner_q  [NUM_FRAMES];
  int unsigned        fifo_q [$];
  bit                 chance_en = 1'b1;
  alloc_result_t      pending_q [$];
  int                 err_cnt = 0;
  int                 mapped_cnt = 0;

  function automatic alloc_result_t frame_table_step(action_e act, int unsigned frm,
                                                     logic [OWNER_W-1:0] own);
    alloc_result_t r;
    int            f;
    int unsigned   h;
    bit            found;
    r = '{frame_index: frm[FRAME_W-1:0], status: ST_OK, evicted: 1'b0};
    found = 1'b0;
    f = 0;
    case (act)
      ACT_ALLOC: begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (!mapped_q[i]) begin
            f = i;
            found = 1'b1;
            break;
          end
        end
        if (!found && chance_en) begin
          while (fifo_q.size() > 0) begin
            h = fifo_q.pop_front();
            if (refbit_q[h]) begin
              refbit_q[h] = 1'b0;
              fifo_q.push_back(h);
            end else begin
              queued_q[h] = 1'b0;
              f = h;
              found = 1'b1;
              r.evicted = 1'b1;
              break;
            end
          end
        end
        if (found) begin
          if (!mapped_q[f]) mapped_cnt++;
          mapped_q[f] = 1'b1;
          owner_q[f] = own;
          r.frame_index = f[FRAME_W-1:0];
        end else begin
          r.frame_index = '0;
          r.status = ST_NOFRAME;
        end
      end
      ACT_REF: begin
        if (queued_q[frm]) begin
          refbit_q[frm] = 1'b1;
        end else begin
          queued_q[frm] = 1'b1;
          refbit_q[frm] = 1'b0;
          fifo_q.push_back(frm);
        end
      end
      ACT_FREE: begin
        if (mapped_q[frm]) begin
          mapped_q[frm] = 1'b0;
          mapped_cnt--;
        end else begin
          r.status = ST_BAD;
        end
      end
      default: begin
        if (!mapped_q[frm] || owner_q[frm] != own) r.status = ST_BAD;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp);
    $display("tb: mismatch %s got %0d expected %0d at %0t", what, got, exp, $realtime);
    err_cnt++;
  endtask

  task automatic send_transaction(action_e act, int unsigned frm,
                                  int unsigned own, int unsigned knd);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= act;
    frame_i <= frm[FRAME_W-1:0];
    owner_i <= own[OWNER_W-1:0];
    kind_i <= knd[KIND_W-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_q.push_back(frame_table_step(act, frm, own[OWNER_W-1:0]));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  int stall_left = 0;
  always @(posedge clk_i) begin
    alloc_result_t exp;
    if (out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", int'(frame_index_o), -1);
      end else begin
        exp = pending_q.pop_front();
        if (frame_index_o !== exp.frame_index)
          report_mismatch("frame_index", int'(frame_index_o), int'(exp.frame_index));
        if (status_o !== exp.status)
          report_mismatch("status", int'(status_o), int'(exp.status));
        if (evicted_o !== exp.evicted)
          report_mismatch("evicted", int'(evicted_o), int'(exp.evicted));
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (out_valid_o && !out_stall_i && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic write_chance(bit en);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    chance_en = en;
  endtask

  function automatic int unsigned pick_frame();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_FRAMES - 1)
                                       : $urandom_range(0, 15);
  endfunction

  task automatic test_directed();
    send_transaction(ACT_CHECK, 0, '0, 0);
    send_transaction(ACT_FREE, 1023, '1, 0);
    send_transaction(ACT_ALLOC, 0, 6'h3f, 2'd3);
    send_transaction(ACT_ALLOC, 1023, 6'h00, 2'd1);
    send_transaction(ACT_ALLOC, 0, 6'h2a, 2'd2);
    send_transaction(ACT_CHECK, 0, 6'h3f, 0);
    send_transaction(ACT_CHECK, 1, 6'h3f, 0);
    send_transaction(ACT_REF, 1023, 0, 0);
    send_transaction(ACT_REF, 1023, 0, 0);
    send_transaction(ACT_FREE, 1, 0, 0);
    send_transaction(ACT_FREE, 1, 0, 0);
    send_transaction(ACT_ALLOC, 0, 6'h15, 2'd0);
    send_transaction(ACT_REF, 512, 6'h3f, 2'd3);
  endtask

  // fill the table so allocation has to evict or fail
  task automatic test_exhaustion(bit en);
    int n;
    while (mapped_cnt < NUM_FRAMES)
      send_transaction(ACT_ALLOC, $urandom, $urandom, $urandom_range(0, 3));
    wait_drained();
    write_chance(en);
    for (int i = 0; i < 40; i++) begin
      n = $urandom_range(0, 9);
      if (n < 4) send_transaction(ACT_REF, pick_frame(), $urandom, $urandom);
      else if (n < 8) send_transaction(ACT_ALLOC, $urandom, $urandom, $urandom);
      else if (n == 8) send_transaction(ACT_CHECK, pick_frame(), $urandom, $urandom);
      else begin
        send_transaction(ACT_FREE, pick_frame(), $urandom, $urandom);
        send_transaction(ACT_ALLOC, $urandom, $urandom, $urandom);
      end
    end
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_transaction(action_e'($urandom_range(0, 3)), pick_frame(),
                       $urandom, $urandom);
      if (i == count / 2) while (pending_q.size() > 0) @(posedge clk_i);
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_chance(1'b1);
    test_directed();
    wait_drained();
    test_random(150);
    test_exhaustion(1'b0);
    test_exhaustion(1'b1);
    write_chance(1'b0);
    test_random(60);
    write_chance(1'b1);
    test_random(60);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
design/fasc_pkg.sv
design/fasc_ram.sv
design/frame_allocator_second_chance_core.sv
design/fasc_checker.sv
dv/tb_frame_allocator_second_chance_core.sv
